// ===== rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/arf_pkg.sv =====
package arf_pkg;

  localparam int REG_COUNT = 16;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int MODE_W    = 4;
  localparam int IN_IDX_W  = 4;
  localparam int IMM_W     = 16;
  localparam int DATA_W    = 32;
  localparam int SHAMT_W   = $clog2(DATA_W);
  localparam int SLOT_CNT  = 1 << IN_IDX_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_CMP = 4'd2,
    MODE_NOT = 4'd3,
    MODE_XOR = 4'd4,
    MODE_OR  = 4'd5,
    MODE_AND = 4'd6,
    MODE_SHL = 4'd7,
    MODE_SHR = 4'd8
  } mode_t;

  typedef logic [SLOT_CNT-1:0][IDX_W-1:0] slot_table_t;

  // incoming register index folded onto the file depth
  function automatic slot_table_t build_slot_table();
    slot_table_t t;
    for (int i = 0; i < SLOT_CNT; i++) begin
      t[i] = IDX_W'(i % REG_COUNT);
    end
    return t;
  endfunction

  localparam slot_table_t SLOT_TABLE = build_slot_table();

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wb_t;

  typedef struct packed {
    logic z;
    logic n;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              write;
    flags_t            flags;
  } alu_res_t;

endpackage

// ===== rtl/arf_ram.sv =====
module arf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/arf_regfile.sv =====
module arf_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [arf_pkg::IDX_W-1:0]   rd_addr_a,
  input  logic [arf_pkg::IDX_W-1:0]   rd_addr_b,
  input  arf_pkg::wb_t                wb,
  output logic [arf_pkg::DATA_W-1:0]  a_data,
  output logic [arf_pkg::DATA_W-1:0]  b_data
);

  logic [arf_pkg::REG_COUNT-1:0] vld_r;
  logic                          a_vld_r;
  logic                          b_vld_r;
  logic                          a_fwd_r;
  logic                          b_fwd_r;
  logic [arf_pkg::DATA_W-1:0]    fwd_data_r;
  logic [arf_pkg::DATA_W-1:0]    ram_a;
  logic [arf_pkg::DATA_W-1:0]    ram_b;

  arf_ram #(
    .WIDTH(arf_pkg::DATA_W),
    .DEPTH(arf_pkg::REG_COUNT)
  ) u_ram (
    .clk    (clk),
    .we     (wb.en),
    .waddr  (wb.addr),
    .wdata  (wb.data),
    .re     (rd_en),
    .raddr_a(rd_addr_a),
    .raddr_b(rd_addr_b),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  // never-written entries read as zero; a write on the read edge is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      a_fwd_r <= 1'b0;
      b_fwd_r <= 1'b0;
    end else begin
      if (wb.en) begin
        vld_r[wb.addr] <= 1'b1;
      end
      if (rd_en) begin
        a_vld_r <= vld_r[rd_addr_a];
        b_vld_r <= vld_r[rd_addr_b];
        a_fwd_r <= wb.en && (wb.addr == rd_addr_a);
        b_fwd_r <= wb.en && (wb.addr == rd_addr_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wb.data;
    end
  end

  assign a_data = a_fwd_r ? fwd_data_r : (a_vld_r ? ram_a : '0);
  assign b_data = b_fwd_r ? fwd_data_r : (b_vld_r ? ram_b : '0);

endmodule

// ===== rtl/arf_alu.sv =====
module arf_alu (
  input  logic [arf_pkg::MODE_W-1:0]  mode,
  input  logic [arf_pkg::DATA_W-1:0]  a,
  input  logic [arf_pkg::DATA_W-1:0]  b,
  input  arf_pkg::flags_t             flags_in,
  output arf_pkg::alu_res_t           res
);

  logic [arf_pkg::DATA_W:0]   sum;
  logic [arf_pkg::DATA_W:0]   diff;
  logic                       big_shift;
  logic [arf_pkg::SHAMT_W-1:0] shamt;
  logic [arf_pkg::DATA_W-1:0] r;
  logic                       upd;
  logic                       wr;
  logic                       v;

  assign sum       = {1'b0, a} + {1'b0, b};
  assign diff      = {1'b0, a} - {1'b0, b};
  assign big_shift = |b[arf_pkg::DATA_W-1:arf_pkg::SHAMT_W];
  assign shamt     = b[arf_pkg::SHAMT_W-1:0];

  always_comb begin
    r   = '0;
    upd = 1'b1;
    wr  = 1'b1;
    v   = flags_in.v;
    case (mode)
      arf_pkg::MODE_ADD: begin
        r = sum[arf_pkg::DATA_W-1:0];
        v = sum[arf_pkg::DATA_W];
      end
      arf_pkg::MODE_SUB: begin
        r = diff[arf_pkg::DATA_W-1:0];
        v = diff[arf_pkg::DATA_W];
      end
      arf_pkg::MODE_CMP: begin
        r  = diff[arf_pkg::DATA_W-1:0];
        v  = diff[arf_pkg::DATA_W];
        wr = 1'b0;
      end
      arf_pkg::MODE_NOT: r = ~a;
      arf_pkg::MODE_XOR: r = a ^ b;
      arf_pkg::MODE_OR:  r = a | b;
      arf_pkg::MODE_AND: r = a & b;
      arf_pkg::MODE_SHL: r = big_shift ? '0 : (a << shamt);
      arf_pkg::MODE_SHR: r = big_shift ? '0 : (a >> shamt);
      default: begin
        upd = 1'b0;
        wr  = 1'b0;
      end
    endcase
  end

  assign res.value   = r;
  assign res.write   = wr;
  assign res.flags.z = upd ? (r == '0) : flags_in.z;
  assign res.flags.n = upd ? r[arf_pkg::DATA_W-1] : flags_in.n;
  assign res.flags.v = v;

endmodule

// ===== rtl/alu_register_flags_unit_top.sv =====
// an accepted word is held in stage s1, its result registered at out_ on commit;
// one word per cycle unless out_stall holds the output; registers are read from a
// two-read-port ram at accept, written back at commit, with same-edge forwarding
// reset: synchronous active-low rst_n clears flags, pipeline and per-register
// valid bits at once, so the file reads as zero with no clearing pass
`include "assert_macros.svh"

module alu_register_flags_unit_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [arf_pkg::MODE_W-1:0]   in_mode,
  input  logic [arf_pkg::IN_IDX_W-1:0] in_dest_index,
  input  logic [arf_pkg::IN_IDX_W-1:0] in_src_index,
  input  logic                         in_use_immediate,
  input  logic [arf_pkg::IMM_W-1:0]    in_immediate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [arf_pkg::DATA_W-1:0]   out_result_value,
  output logic                         out_wrote_register,
  output logic                         out_zero_flag,
  output logic                         out_negative_flag,
  output logic                         out_overflow_flag
);

  logic                        in_accept;
  logic                        s1_adv;
  logic                        commit;
  logic                        cmp_commit;
  logic [arf_pkg::IDX_W-1:0]   rd_a;
  logic [arf_pkg::IDX_W-1:0]   rd_b;
  logic                        s1_valid_r;
  logic [arf_pkg::MODE_W-1:0]  s1_mode_r;
  logic [arf_pkg::IDX_W-1:0]   s1_dest_r;
  logic                        s1_use_imm_r;
  logic [arf_pkg::IMM_W-1:0]   s1_imm_r;
  logic [arf_pkg::DATA_W-1:0]  a_data;
  logic [arf_pkg::DATA_W-1:0]  b_reg;
  logic [arf_pkg::DATA_W-1:0]  b_op;
  arf_pkg::flags_t             flags_r;
  arf_pkg::alu_res_t           alu_res;
  arf_pkg::wb_t                wb;
  logic                        out_valid_r;
  logic [arf_pkg::DATA_W-1:0]  out_value_r;
  logic                        out_wrote_r;
  arf_pkg::flags_t             out_flags_r;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign commit    = s1_valid_r && s1_adv;

  assign cmp_commit = commit && (s1_mode_r == arf_pkg::MODE_CMP);

  assign rd_a = arf_pkg::SLOT_TABLE[in_dest_index];
  assign rd_b = arf_pkg::SLOT_TABLE[in_src_index];

  assign wb.en   = commit && alu_res.write;
  assign wb.addr = s1_dest_r;
  assign wb.data = alu_res.value;

  arf_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr_a(rd_a),
    .rd_addr_b(rd_b),
    .wb       (wb),
    .a_data   (a_data),
    .b_data   (b_reg)
  );

  assign b_op = s1_use_imm_r ? {{(arf_pkg::DATA_W - arf_pkg::IMM_W){1'b0}}, s1_imm_r} : b_reg;

  arf_alu u_alu (
    .mode    (s1_mode_r),
    .a       (a_data),
    .b       (b_op),
    .flags_in(flags_r),
    .res     (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        flags_r     <= alu_res.flags;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r    <= in_mode;
      s1_dest_r    <= rd_a;
      s1_use_imm_r <= in_use_immediate;
      s1_imm_r     <= in_immediate;
    end
    if (commit) begin
      out_value_r <= alu_res.value;
      out_wrote_r <= alu_res.write;
      out_flags_r <= alu_res.flags;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_value_r;
  assign out_wrote_register = out_wrote_r;
  assign out_zero_flag      = out_flags_r.z;
  assign out_negative_flag  = out_flags_r.n;
  assign out_overflow_flag  = out_flags_r.v;

  `AST_IMPLIES(a_stall_only_full, clk, rst_n, in_stall, s1_valid_r, "stall with empty stage")
  `AST_NEXT(a_commit_to_out, clk, rst_n, commit, out_valid_r, "committed word not presented")
  `AST_IMPLIES(a_cmp_no_write, clk, rst_n, cmp_commit, !wb.en, "cmp wrote a register")
  `AST_NEXT(a_flags_hold, clk, rst_n, !commit, $stable(flags_r), "flags moved without commit")

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import arf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1100;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_CYCLES = 160;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

  // register file and flag shadow, with the queue of results still owed
  class alu_shadow;
    logic [DATA_W-1:0] regs [REG_COUNT];
    bit zf, nf, vf;
    alu_res_t owed_results [$];
    int unsigned words_per_mode [16];

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      zf = 0;
      nf = 0;
      vf = 0;
      owed_results.delete();
    endfunction

    function void note_instr(logic [MODE_W-1:0] mode, logic [IN_IDX_W-1:0] d_idx,
                             logic [IN_IDX_W-1:0] s_idx, bit imm_sel,
                             logic [IMM_W-1:0] imm);
      int d, s;
      logic [DATA_W-1:0] a, b, r;
      bit wr, known;
      alu_res_t res;
      d = int'(d_idx) % REG_COUNT;
      s = int'(s_idx) % REG_COUNT;
      a = regs[d];
      b = imm_sel ? DATA_W'(imm) : regs[s];
      r = '0;
      wr = 1;
      known = 1;
      case (mode)
        MODE_ADD: begin
          r = a + b;
          vf = (r < a);
        end
        MODE_SUB: begin
          r = a - b;
          vf = (a < b);
        end
        MODE_CMP: begin
          r = a - b;
          vf = (a < b);
          wr = 0;
        end
        MODE_NOT: r = ~a;
        MODE_XOR: r = a ^ b;
        MODE_OR:  r = a | b;
        MODE_AND: r = a & b;
        MODE_SHL: r = (b >= DATA_W) ? '0 : a << b;
        MODE_SHR: r = (b >= DATA_W) ? '0 : a >> b;
        default: begin
          known = 0;
          wr = 0;
        end
      endcase
      if (known) begin
        zf = (r == '0);
        nf = r[DATA_W-1];
        if (wr) regs[d] = r;
      end
      res.value = r;
      res.write = wr;
      res.flags.z = zf;
      res.flags.n = nf;
      res.flags.v = vf;
      owed_results.push_back(res);
      words_per_mode[mode]++;
    endfunction

    function string compare_word(alu_res_t got);
      string msg;
      alu_res_t want;
      msg = "";
      want = owed_results.pop_front();
      if (got.value !== want.value)
        msg = {msg, $sformatf(" result_value %h want %h", got.value, want.value)};
      if (got.write !== want.write)
        msg = {msg, $sformatf(" wrote_register %b want %b", got.write, want.write)};
      if (got.flags.z !== want.flags.z)
        msg = {msg, $sformatf(" zero_flag %b want %b", got.flags.z, want.flags.z)};
      if (got.flags.n !== want.flags.n)
        msg = {msg, $sformatf(" negative_flag %b want %b", got.flags.n, want.flags.n)};
      if (got.flags.v !== want.flags.v)
        msg = {msg, $sformatf(" overflow_flag %b want %b", got.flags.v, want.flags.v)};
      return msg;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [IN_IDX_W-1:0] in_dest_index = '0;
  logic [IN_IDX_W-1:0] in_src_index = '0;
  logic in_use_immediate = 0;
  logic [IMM_W-1:0] in_immediate = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [DATA_W-1:0] out_result_value;
  logic out_wrote_register;
  logic out_zero_flag;
  logic out_negative_flag;
  logic out_overflow_flag;

  alu_shadow shadow = new();
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned holds_done = 0;
  int unsigned drains_done = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit long_hold_req = 0;
  bit quiet = 0;

  alu_register_flags_unit_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_dest_index     (in_dest_index),
    .in_src_index      (in_src_index),
    .in_use_immediate  (in_use_immediate),
    .in_immediate      (in_immediate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_wrote_register(out_wrote_register),
    .out_zero_flag     (out_zero_flag),
    .out_negative_flag (out_negative_flag),
    .out_overflow_flag (out_overflow_flag)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycles,
               shadow.owed_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic report(string what);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d:%s", cycles, what);
  endtask

  // result side: check the word taken at this edge, then pick the next stall
  always @(posedge clk) begin
    alu_res_t got;
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      got.value = out_result_value;
      got.write = out_wrote_register;
      got.flags.z = out_zero_flag;
      got.flags.n = out_negative_flag;
      got.flags.v = out_overflow_flag;
      results_checked++;
      if (shadow.owed_results.size() == 0) begin
        report($sformatf(" unexpected result %h", got.value));
      end else begin
        msg = shadow.compare_word(got);
        if (msg != "") report(msg);
      end
    end
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(6) == 0) begin
      stall_left = $urandom_range(19, 1) - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_instr(logic [MODE_W-1:0] mode, logic [IN_IDX_W-1:0] d_idx,
                            logic [IN_IDX_W-1:0] s_idx, bit imm_sel,
                            logic [IMM_W-1:0] imm);
    if (!quiet && $urandom_range(5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_dest_index <= d_idx;
    in_src_index <= s_idx;
    in_use_immediate <= imm_sel;
    in_immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_instr(mode, d_idx, s_idx, imm_sel, imm);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (shadow.owed_results.size() != 0);
    drains_done++;
  endtask

  task automatic random_instr();
    logic [MODE_W-1:0] mode;
    logic [IMM_W-1:0] imm;
    int unsigned pick;
    mode = ($urandom_range(99) < 8) ? MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO))
                                     : MODE_W'($urandom_range(MODE_SHR, MODE_ADD));
    pick = $urandom_range(9);
    if (pick < 4) imm = IMM_W'($urandom_range(40));
    else if (pick == 4) imm = $urandom_range(1) ? '1 : '0;
    else imm = IMM_W'($urandom);
    send_instr(mode, IN_IDX_W'($urandom), IN_IDX_W'($urandom), $urandom_range(1), imm);
  endtask

  initial begin
    shadow.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;

    send_instr(MODE_ADD, 1, 0, 1, 16'hFFFF);
    send_instr(MODE_SHL, 1, 0, 1, 16'd16);
    send_instr(MODE_OR, 1, 0, 1, 16'hFFFF);
    send_instr(MODE_ADD, 2, 0, 1, 16'd1);
    send_instr(MODE_ADD, 1, 2, 0, 16'h1234);
    send_instr(MODE_NOT, 1, 15, 1, 16'hA5A5);
    send_instr(MODE_SUB, 3, 2, 0, 16'h0);
    send_instr(MODE_CMP, 2, 2, 0, 16'hFFFF);
    send_instr(MODE_CMP, 0, 7, 1, 16'hFFFF);
    send_instr(MODE_XOR, 3, 3, 0, 16'h0);
    send_instr(MODE_AND, 1, 0, 1, 16'h0);
    send_instr(MODE_NOT, 1, 0, 0, 16'h0);
    send_instr(MODE_SHR, 1, 0, 1, 16'd31);
    send_instr(MODE_SHR, 1, 0, 1, 16'd32);
    send_instr(MODE_NOT, 4, 9, 0, 16'hFFFF);
    send_instr(MODE_SHL, 4, 0, 1, 16'd31);
    send_instr(MODE_SHR, 4, 0, 1, 16'd0);
    send_instr(MODE_SHL, 2, 4, 0, 16'd0);
    send_instr(MODE_SPARE_LO, 4, 4, 0, 16'h5555);
    send_instr(MODE_ADD, 15, 0, 1, 16'hFFFF);
    send_instr(MODE_XOR, 15, 4, 0, 16'h0);
    send_instr(MODE_SUB, 0, 0, 1, 16'h0);
    send_instr(MODE_SPARE_HI, 15, 15, 1, 16'hFFFF);
    send_instr(MODE_AND, 15, 4, 0, 16'hFFFF);
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 400) long_hold_req = 1;
      if (i == 700) drain();
      if (i == RANDOM_WORDS - QUIET_TAIL) quiet = 1;
      random_instr();
    end

    in_valid <= 0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d results checked over %0d cycles; words per mode:", results_checked,
             cycles);
    $display("  %p, %0d long output holds, %0d full drains", shadow.words_per_mode,
             holds_done, drains_done);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
